>>> sv/dcr_pkg.sv
// Shared types and constants for the DDC/CI message receiver.
package dcr_pkg;

  localparam int MAX_MSG_LEN = 64;
  localparam logic [7:0] MAX_LEN_B = 8'(MAX_MSG_LEN);
  localparam logic [7:0] HOST_ADDR_RST = 8'h51;
  localparam logic [7:0] DISPLAY_ADDR_RST = 8'h6e;
  localparam logic [6:0] LEN_MASK = 7'h7f;

  localparam logic [2:0] REQ_RX = 3'd0;
  localparam logic [2:0] REQ_TX = 3'd1;
  localparam logic [2:0] REQ_ABORT = 3'd2;
  localparam logic [2:0] REQ_LOAD = 3'd3;
  localparam logic [2:0] REQ_RELEASE = 3'd4;

  localparam logic [1:0] PORT_ANALOG = 2'd0;
  localparam logic [1:0] PORT_UNUSED = 2'd3;

  localparam logic CFG_HOST = 1'b0;
  localparam logic CFG_DISPLAY = 1'b1;

  // receive phase reported once a message has completed
  localparam logic [2:0] PHASE_DONE = 3'd5;

  typedef enum logic [2:0] {
    OP_RX,
    OP_TX,
    OP_ABORT,
    OP_LOAD,
    OP_RELEASE,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic [1:0] port;
  } cmd_t;

  typedef struct packed {
    logic       buf_write;
    logic [5:0] buf_index;
    logic [7:0] buf_byte;
    logic       msg_complete;
    logic [1:0] msg_port;
    logic       tx_write;
    logic [7:0] tx_byte;
    logic       tx_active;
    logic [2:0] rx_phase;
    logic       busy_res;
  } result_t;

endpackage

>>> sv/dcr_front.sv
// Front end: decodes bus events and queues them for the framer.
module dcr_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [2:0]    req_type,
  input  logic [7:0]    data_byte,
  input  logic [1:0]    source_port,
  output logic          cmd_valid,
  output dcr_pkg::cmd_t cmd,
  input  logic          cmd_pop
);
  import dcr_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       dec;
  logic       do_push;
  logic       do_pop;

  always_comb begin
    case (req_type)
      REQ_RX:      dec.op = OP_RX;
      REQ_TX:      dec.op = OP_TX;
      REQ_ABORT:   dec.op = OP_ABORT;
      REQ_LOAD:    dec.op = OP_LOAD;
      REQ_RELEASE: dec.op = OP_RELEASE;
      default:     dec.op = OP_NONE;
    endcase
    dec.data = data_byte;
    // port 3 is not a real input, fold it onto analog
    dec.port = (source_port == PORT_UNUSED) ? PORT_ANALOG : source_port;
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

>>> sv/dcr_back.sv
// Back end: receive/transmit framer state and result queue.
module dcr_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [7:0]       cfg_data,
  input  logic             cmd_valid,
  input  dcr_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  output logic             res_valid,
  output dcr_pkg::result_t res,
  input  logic             res_pop
);
  import dcr_pkg::*;

  typedef enum logic [2:0] {
    RX_CLEAR,
    RX_LENGTH,
    RX_COMMAND,
    RX_BODY,
    RX_CHECK,
    RX_DONE
  } rx_state_t;

  logic [7:0] host_addr;
  logic [7:0] display_addr;

  rx_state_t  rx_state, rx_state_next;
  logic [5:0] rx_index, rx_index_next;
  logic [6:0] rx_remaining, rx_remaining_next;
  logic [7:0] rx_checksum, rx_checksum_next;
  logic       busy_flag, busy_flag_next;
  logic [1:0] last_port, last_port_next;
  logic       tx_status, tx_status_next;
  logic [6:0] tx_remaining, tx_remaining_next;

  result_t    r;
  logic [6:0] rem_dec;
  logic [7:0] len;

  result_t    q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       fire;
  logic       do_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      host_addr    <= HOST_ADDR_RST;
      display_addr <= DISPLAY_ADDR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HOST:    host_addr <= cfg_data;
        CFG_DISPLAY: display_addr <= cfg_data;
        default:     host_addr <= host_addr;
      endcase
    end
  end

  assign rem_dec = rx_remaining - 7'd1;
  assign len     = {1'b0, cmd.data[6:0]};

  always_comb begin
    rx_state_next     = rx_state;
    rx_index_next     = rx_index;
    rx_remaining_next = rx_remaining;
    rx_checksum_next  = rx_checksum;
    busy_flag_next    = busy_flag;
    last_port_next    = last_port;
    tx_status_next    = tx_status;
    tx_remaining_next = tx_remaining;
    r = '0;
    case (cmd.op)
      OP_RX: begin
        case (rx_state)
          RX_CLEAR: begin
            if (cmd.data == host_addr) begin
              rx_state_next    = RX_LENGTH;
              rx_checksum_next = host_addr ^ display_addr;
            end else begin
              rx_index_next = '0;
            end
          end
          RX_LENGTH: begin
            rx_remaining_next = cmd.data[6:0];
            r.buf_write       = 1'b1;
            r.buf_index       = rx_index;
            r.buf_byte        = cmd.data;
            rx_index_next     = rx_index + 6'd1;
            rx_checksum_next  = rx_checksum ^ cmd.data;
            rx_state_next     = RX_COMMAND;
            // null or oversize message completes at once
            if (len == 8'd0 || len >= MAX_LEN_B) begin
              rx_state_next  = RX_DONE;
              busy_flag_next = 1'b1;
              r.msg_complete = 1'b1;
            end
          end
          RX_COMMAND, RX_BODY: begin
            rx_state_next     = RX_BODY;
            r.buf_write       = 1'b1;
            r.buf_index       = rx_index;
            r.buf_byte        = cmd.data;
            rx_index_next     = rx_index + 6'd1;
            rx_checksum_next  = rx_checksum ^ cmd.data;
            rx_remaining_next = rem_dec & LEN_MASK;
            if (rem_dec == 7'd0) begin
              rx_state_next = RX_CHECK;
            end
          end
          RX_CHECK: begin
            if (rx_checksum == cmd.data) begin
              last_port_next = cmd.port;
              rx_state_next  = RX_DONE;
              busy_flag_next = 1'b1;
              r.msg_complete = 1'b1;
            end else begin
              rx_state_next = RX_CLEAR;
              rx_index_next = '0;
            end
          end
          default: begin
            if (!busy_flag) begin
              rx_state_next = RX_CLEAR;
              rx_index_next = '0;
            end
          end
        endcase
      end
      OP_TX: begin
        r.tx_write = 1'b1;
        if (tx_remaining == 7'd0) begin
          tx_status_next = 1'b0;
        end else begin
          tx_status_next    = 1'b1;
          r.tx_byte         = cmd.data;
          tx_remaining_next = tx_remaining - 7'd1;
        end
      end
      OP_ABORT: begin
        r.tx_write     = 1'b1;
        r.tx_byte      = cmd.data;
        tx_status_next = 1'b0;
        rx_state_next  = RX_CLEAR;
        rx_index_next  = '0;
      end
      OP_LOAD: begin
        tx_remaining_next = cmd.data[7] ? LEN_MASK : cmd.data[6:0];
      end
      OP_RELEASE: begin
        busy_flag_next = 1'b0;
      end
      default: begin
        busy_flag_next = busy_flag;
      end
    endcase
    r.msg_port  = last_port_next;
    r.tx_active = tx_status_next;
    r.rx_phase  = rx_state_next;
    r.busy_res  = busy_flag_next;
  end

  assign res_valid = (count != 2'd0);
  assign res       = q[rd_ptr];
  assign cmd_pop   = (count != 2'd2);
  assign fire      = cmd_valid && cmd_pop;
  assign do_pop    = res_pop && res_valid;

  always_ff @(posedge clk) begin
    if (fire) begin
      q[wr_ptr] <= r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_state     <= RX_CLEAR;
      rx_index     <= '0;
      rx_remaining <= '0;
      rx_checksum  <= '0;
      busy_flag    <= 1'b0;
      last_port    <= '0;
      tx_status    <= 1'b0;
      tx_remaining <= '0;
      wr_ptr       <= 1'b0;
      rd_ptr       <= 1'b0;
      count        <= 2'd0;
    end else begin
      if (fire) begin
        rx_state     <= rx_state_next;
        rx_index     <= rx_index_next;
        rx_remaining <= rx_remaining_next;
        rx_checksum  <= rx_checksum_next;
        busy_flag    <= busy_flag_next;
        last_port    <= last_port_next;
        tx_status    <= tx_status_next;
        tx_remaining <= tx_remaining_next;
        wr_ptr       <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, fire} - {1'b0, do_pop};
    end
  end

endmodule

>>> sv/ddc_ci_message_receiver.sv
// Top level of the DDC/CI message receiver: event queue, framer, result queue.
//
//   Channel   Direction  Handshake        Payload
//   input     in         push / full      req_type, data_byte, source_port
//   result    out        empty / pop      buf_*, msg_*, tx_*, rx_phase, busy_res
//   config    in         cfg_we           cfg_index, cfg_data
//
// One event per cycle sustained unless a full result queue stalls the framer; a
// result reaches the result ports via the event and result queue registers.
// Both the event queue and the result queue hold two entries; full rises once
// the event queue holds two and the framer is stalled by a full result queue.
// Reset (rst, synchronous) clears framer state and restores the address registers.
module ddc_ci_message_receiver (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [2:0] req_type,
  input  logic [7:0] data_byte,
  input  logic [1:0] source_port,
  output logic       empty,
  input  logic       pop,
  output logic       buf_write,
  output logic [5:0] buf_index,
  output logic [7:0] buf_byte,
  output logic       msg_complete,
  output logic [1:0] msg_port,
  output logic       tx_write,
  output logic [7:0] tx_byte,
  output logic       tx_active,
  output logic [2:0] rx_phase,
  output logic       busy_res,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);
  import dcr_pkg::*;

  cmd_t    cmd;
  logic    cmd_valid;
  logic    cmd_pop;
  result_t res;
  logic    res_valid;

  dcr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .req_type    (req_type),
    .data_byte   (data_byte),
    .source_port (source_port),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  dcr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_pop   (pop)
  );

  assign empty        = !res_valid;
  assign buf_write    = res.buf_write;
  assign buf_index    = res.buf_index;
  assign buf_byte     = res.buf_byte;
  assign msg_complete = res.msg_complete;
  assign msg_port     = res.msg_port;
  assign tx_write     = res.tx_write;
  assign tx_byte      = res.tx_byte;
  assign tx_active    = res.tx_active;
  assign rx_phase     = res.rx_phase;
  assign busy_res     = res.busy_res;

`ifndef SYNTHESIS
  a_cmd_held: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_pop |=> cmd_valid && $stable(cmd))
    else $error("queued event lost while framer stalled");

  a_no_dual_write: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(buf_write && tx_write))
    else $error("buffer and transmit writes in one result");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    !empty && msg_complete |-> busy_res && rx_phase == PHASE_DONE)
    else $error("completed message without busy");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> rx_phase <= PHASE_DONE)
    else $error("receive phase out of range");
`endif

endmodule

>>> bench/ddc_ci_message_receiver_test.sv
// Testbench for the DDC/CI message receiver: directed frames, then random bus traffic.
`timescale 1ns / 100ps

module ddc_ci_message_receiver_test;
  import dcr_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 106;

  typedef enum logic [2:0] {
    PH_CLEAR,
    PH_LENGTH,
    PH_COMMAND,
    PH_BODY,
    PH_CHECK,
    PH_DONE
  } phase_t;

  typedef struct {
    logic [2:0] req;
    logic [7:0] data;
    logic [1:0] port;
    logic       fixed;
    result_t    want;
  } bus_event_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [2:0] req_type = REQ_RX;
  logic [7:0] data_byte = 8'h00;
  logic [1:0] source_port = PORT_ANALOG;
  logic       empty;
  logic       pop = 1'b0;
  logic       buf_write;
  logic [5:0] buf_index;
  logic [7:0] buf_byte;
  logic       msg_complete;
  logic [1:0] msg_port;
  logic       tx_write;
  logic [7:0] tx_byte;
  logic       tx_active;
  logic [2:0] rx_phase;
  logic       busy_res;
  logic       cfg_we = 1'b0;
  logic       cfg_index = CFG_HOST;
  logic [7:0] cfg_data = 8'h00;

  ddc_ci_message_receiver i_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .req_type(req_type),
    .data_byte(data_byte),
    .source_port(source_port),
    .empty(empty),
    .pop(pop),
    .buf_write(buf_write),
    .buf_index(buf_index),
    .buf_byte(buf_byte),
    .msg_complete(msg_complete),
    .msg_port(msg_port),
    .tx_write(tx_write),
    .tx_byte(tx_byte),
    .tx_active(tx_active),
    .rx_phase(rx_phase),
    .busy_res(busy_res),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // framer model state
  logic [7:0] host_reg = HOST_ADDR_RST;
  logic [7:0] disp_reg = DISPLAY_ADDR_RST;
  phase_t     fr_state = PH_CLEAR;
  logic [5:0] fr_index = '0;
  logic [6:0] fr_left = '0;
  logic [7:0] fr_sum = '0;
  logic       fr_busy = 1'b0;
  logic [1:0] fr_port = PORT_ANALOG;
  logic       tx_on = 1'b0;
  logic [6:0] tx_left = '0;

  result_t    predicted_results[$];
  bus_event_t bus_events[$];
  int         mismatches = 0;
  int         result_count = 0;
  int         cycles = 0;
  int         send_idle_pct = 0;
  int         pop_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic result_t frame_event(input logic [2:0] req, input logic [7:0] b,
                                          input logic [1:0] src);
    result_t    r;
    logic [1:0] p;
    r = '0;
    p = (src == PORT_UNUSED) ? PORT_ANALOG : src;
    case (req)
      REQ_RX: begin
        case (fr_state)
          PH_CLEAR: begin
            if (b == host_reg) begin
              fr_state = PH_LENGTH;
              fr_sum = host_reg ^ disp_reg;
            end else begin
              fr_index = '0;
            end
          end
          PH_LENGTH: begin
            fr_left = b[6:0];
            r.buf_write = 1'b1;
            r.buf_index = fr_index;
            r.buf_byte = b;
            fr_index = fr_index + 6'd1;
            fr_sum = fr_sum ^ b;
            // null or oversize length completes at once, port kept
            if (fr_left == 7'd0 || fr_left >= MAX_MSG_LEN) begin
              fr_state = PH_DONE;
              fr_busy = 1'b1;
              r.msg_complete = 1'b1;
            end else begin
              fr_state = PH_COMMAND;
            end
          end
          PH_COMMAND, PH_BODY: begin
            r.buf_write = 1'b1;
            r.buf_index = fr_index;
            r.buf_byte = b;
            fr_index = fr_index + 6'd1;
            fr_sum = fr_sum ^ b;
            fr_left = fr_left - 7'd1;
            fr_state = (fr_left == 7'd0) ? PH_CHECK : PH_BODY;
          end
          PH_CHECK: begin
            if (fr_sum == b) begin
              fr_port = p;
              fr_state = PH_DONE;
              fr_busy = 1'b1;
              r.msg_complete = 1'b1;
            end else begin
              fr_state = PH_CLEAR;
              fr_index = '0;
            end
          end
          default: begin
            if (!fr_busy) begin
              fr_state = PH_CLEAR;
              fr_index = '0;
            end
          end
        endcase
      end
      REQ_TX: begin
        r.tx_write = 1'b1;
        if (tx_left == 7'd0) begin
          tx_on = 1'b0;
        end else begin
          tx_on = 1'b1;
          r.tx_byte = b;
          tx_left = tx_left - 7'd1;
        end
      end
      REQ_ABORT: begin
        r.tx_write = 1'b1;
        r.tx_byte = b;
        tx_on = 1'b0;
        fr_state = PH_CLEAR;
        fr_index = '0;
      end
      REQ_LOAD: tx_left = b[7] ? LEN_MASK : b[6:0];
      REQ_RELEASE: fr_busy = 1'b0;
      default: ;
    endcase
    r.msg_port = fr_port;
    r.tx_active = tx_on;
    r.rx_phase = fr_state;
    r.busy_res = fr_busy;
    return r;
  endfunction

  task automatic add_row(input logic [2:0] req, input logic [7:0] data, input logic [1:0] port,
                         input logic fixed, input result_t want);
    bus_event_t ev;
    ev.req = req;
    ev.data = data;
    ev.port = port;
    ev.fixed = fixed;
    ev.want = want;
    bus_events.push_back(ev);
  endtask

  task automatic send(input bus_event_t ev);
    result_t want;
    // occasionally hold off until the block has drained
    if ($urandom_range(99) == 0 && predicted_results.size() != 0) begin
      push <= 1'b0;
      while (predicted_results.size() != 0) @(posedge clk);
    end
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    req_type <= ev.req;
    data_byte <= ev.data;
    source_port <= ev.port;
    @(posedge clk);
    while (full) @(posedge clk);
    want = frame_event(ev.req, ev.data, ev.port);
    predicted_results.push_back(ev.fixed ? ev.want : want);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == CFG_HOST) host_reg = val;
    else disp_reg = val;
  endtask

  // mostly well-formed frames with random content, plus transmit traffic and noise
  task automatic plan_traffic(input int target);
    int         pick;
    int         len;
    int         i;
    int         n;
    logic [7:0] lb;
    logic [7:0] sum;
    logic [7:0] b;
    while (bus_events.size() < target) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        if ($urandom_range(9) != 0) add_row(REQ_RELEASE, 8'($urandom), 2'($urandom), 1'b0, '0);
        b = 8'($urandom);
        if (b == host_reg) b = ~b;
        add_row(REQ_RX, b, 2'($urandom), 1'b0, '0);
        add_row(REQ_RX, host_reg, 2'($urandom), 1'b0, '0);
        pick = $urandom_range(99);
        if (pick < 82) len = $urandom_range(1, 8);
        else if (pick < 85) len = MAX_MSG_LEN - 1;
        else if (pick < 90) len = $urandom_range(9, MAX_MSG_LEN - 1);
        else if (pick < 95) len = 0;
        else len = $urandom_range(MAX_MSG_LEN, 127);
        lb = {1'($urandom), 7'(len)};
        sum = host_reg ^ disp_reg ^ lb;
        add_row(REQ_RX, lb, 2'($urandom), 1'b0, '0);
        if (len != 0 && len < MAX_MSG_LEN) begin
          for (i = 0; i < len; i++) begin
            if ($urandom_range(19) == 0)
              add_row(3'($urandom_range(1, 7)), 8'($urandom), 2'($urandom), 1'b0, '0);
            b = 8'($urandom);
            sum = sum ^ b;
            add_row(REQ_RX, b, 2'($urandom), 1'b0, '0);
          end
          if ($urandom_range(9) == 0) sum = sum ^ 8'($urandom_range(1, 255));
          add_row(REQ_RX, sum, 2'($urandom), 1'b0, '0);
        end
      end else if (pick < 82) begin
        b = ($urandom_range(1) == 0) ? 8'($urandom_range(0, 6)) : 8'($urandom);
        add_row(REQ_LOAD, b, 2'($urandom), 1'b0, '0);
        n = $urandom_range(1, 8);
        for (i = 0; i < n; i++) add_row(REQ_TX, 8'($urandom), 2'($urandom), 1'b0, '0);
      end else if (pick < 88) begin
        add_row(REQ_ABORT, 8'($urandom), 2'($urandom), 1'b0, '0);
      end else if (pick < 95) begin
        add_row(REQ_RX, 8'($urandom), 2'($urandom), 1'b0, '0);
      end else begin
        add_row(3'($urandom_range(4, 7)), 8'($urandom), 2'($urandom), 1'b0, '0);
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0h, want %0h", result_count, name, got,
                                want));
  endtask

  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  // result side: compare each transfer with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && pop && !empty) begin
      if (predicted_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing outstanding", result_count));
      end else begin
        want = predicted_results.pop_front();
        check_field("buf_write", 8'(buf_write), 8'(want.buf_write));
        check_field("buf_index", 8'(buf_index), 8'(want.buf_index));
        check_field("buf_byte", buf_byte, want.buf_byte);
        check_field("msg_complete", 8'(msg_complete), 8'(want.msg_complete));
        check_field("msg_port", 8'(msg_port), 8'(want.msg_port));
        check_field("tx_write", 8'(tx_write), 8'(want.tx_write));
        check_field("tx_byte", tx_byte, want.tx_byte);
        check_field("tx_active", 8'(tx_active), 8'(want.tx_active));
        check_field("rx_phase", 8'(rx_phase), 8'(want.rx_phase));
        check_field("busy_res", 8'(busy_res), 8'(want.busy_res));
      end
      result_count++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int         ph;
    logic [7:0] h;
    logic [7:0] d;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed frames at the reset addresses (host 0x51, display 0x6e)
    add_row(REQ_RX, 8'h00, 2'd0, 1'b1,
            {1'b0, 6'd0, 8'h00, 1'b0, 2'd0, 1'b0, 8'h00, 1'b0, PH_CLEAR, 1'b0});
    add_row(REQ_RX, 8'h51, 2'd1, 1'b1,
            {1'b0, 6'd0, 8'h00, 1'b0, 2'd0, 1'b0, 8'h00, 1'b0, PH_LENGTH, 1'b0});
    // null length
    add_row(REQ_RX, 8'h00, 2'd1, 1'b1,
            {1'b1, 6'd0, 8'h00, 1'b1, 2'd0, 1'b0, 8'h00, 1'b0, PH_DONE, 1'b1});
    // byte while busy is ignored
    add_row(REQ_RX, 8'h51, 2'd2, 1'b1,
            {1'b0, 6'd0, 8'h00, 1'b0, 2'd0, 1'b0, 8'h00, 1'b0, PH_DONE, 1'b1});
    add_row(REQ_RELEASE, 8'h00, 2'd0, 1'b1,
            {1'b0, 6'd0, 8'h00, 1'b0, 2'd0, 1'b0, 8'h00, 1'b0, PH_DONE, 1'b0});
    add_row(REQ_RX, 8'hFF, 2'd3, 1'b1,
            {1'b0, 6'd0, 8'h00, 1'b0, 2'd0, 1'b0, 8'h00, 1'b0, PH_CLEAR, 1'b0});
    add_row(REQ_RX, 8'h51, 2'd0, 1'b0, '0);
    // oversize length with the control bit set
    add_row(REQ_RX, 8'hC0, 2'd0, 1'b1,
            {1'b1, 6'd0, 8'hC0, 1'b1, 2'd0, 1'b0, 8'h00, 1'b0, PH_DONE, 1'b1});
    add_row(REQ_RELEASE, 8'hFF, 2'd3, 1'b0, '0);
    add_row(REQ_RX, 8'h51, 2'd0, 1'b0, '0);
    add_row(REQ_RX, 8'h51, 2'd0, 1'b0, '0);
    add_row(REQ_RX, 8'h82, 2'd1, 1'b0, '0);
    add_row(REQ_RX, 8'hFF, 2'd2, 1'b0, '0);
    add_row(REQ_RX, 8'h00, 2'd3, 1'b0, '0);
    add_row(REQ_RX, 8'h42, 2'd2, 1'b0, '0);
    add_row(REQ_RELEASE, 8'h00, 2'd1, 1'b0, '0);
    add_row(REQ_RX, 8'h51, 2'd0, 1'b0, '0);
    add_row(REQ_RX, 8'h51, 2'd0, 1'b0, '0);
    add_row(REQ_RX, 8'h01, 2'd0, 1'b0, '0);
    add_row(REQ_RX, 8'h55, 2'd0, 1'b0, '0);
    // bad checksum
    add_row(REQ_RX, 8'h00, 2'd1, 1'b1,
            {1'b0, 6'd0, 8'h00, 1'b0, 2'd2, 1'b0, 8'h00, 1'b0, PH_CLEAR, 1'b0});
    add_row(REQ_LOAD, 8'hFF, 2'd0, 1'b0, '0);
    add_row(REQ_TX, 8'h7E, 2'd0, 1'b0, '0);
    add_row(REQ_ABORT, 8'hA5, 2'd3, 1'b1,
            {1'b0, 6'd0, 8'h00, 1'b0, 2'd2, 1'b1, 8'hA5, 1'b0, PH_CLEAR, 1'b0});
    add_row(REQ_LOAD, 8'h00, 2'd0, 1'b0, '0);
    // transmit exhausted drives zero
    add_row(REQ_TX, 8'h33, 2'd1, 1'b1,
            {1'b0, 6'd0, 8'h00, 1'b0, 2'd2, 1'b1, 8'h00, 1'b0, PH_CLEAR, 1'b0});
    add_row(3'(OP_NONE), 8'h99, 2'd2, 1'b0, '0);

    while (bus_events.size() != 0) send(bus_events.pop_front());
    push <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; pop_stall_pct = 0; end
        1: begin send_idle_pct = 83; pop_stall_pct = 0; end
        2: begin send_idle_pct = 0; pop_stall_pct = 83; end
        default: begin send_idle_pct = 31; pop_stall_pct = 31; end
      endcase
      case (ph)
        0: begin h = 8'h00; d = 8'hFF; end
        1: begin h = 8'hFF; d = 8'h00; end
        2: begin h = HOST_ADDR_RST; d = DISPLAY_ADDR_RST; end
        default: begin h = 8'($urandom); d = 8'($urandom); end
      endcase
      write_reg(CFG_HOST, h);
      write_reg(CFG_DISPLAY, d);
      cfg_we <= 1'b0;
      plan_traffic(PHASE_ITEMS);
      while (bus_events.size() != 0) send(bus_events.pop_front());
      push <= 1'b0;
      while (predicted_results.size() != 0) @(posedge clk);
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

>>> files.f
sv/dcr_pkg.sv
sv/dcr_front.sv
sv/dcr_back.sv
sv/ddc_ci_message_receiver.sv
bench/ddc_ci_message_receiver_test.sv
